@@ rtl/mme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Store geometry, operand and accumulator widths, input codes, control structs.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DIM_W      = 4;
    localparam int DATA_WIDTH = 16;
    localparam int VALUE_W    = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

    // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/matrix_multiply_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit: C = A x B on stored signed fixed-point elements
//
// Input channel (i_in_valid / o_in_stall): one word per cycle while idle. Mode load A or
// load B writes one element at (row, col). Mode run walks
// C in row-major order; mode 3 is dropped. The unit stalls input while a run
// is in progress.
// Output channel (o_out_valid / i_out_stall): one word per C element with its
// row, column, exact 40-bit sum and a last flag on the final element.
// Each C element goes through the single multiplier and accumulator as K
// reads, read latency, product register, accumulate and emit; a run takes
// longer if the receiver stalls.
// A stalled output holds its word; the sequencer waits in the emit step
// until the output register frees up, nothing is dropped.
// Reset (synchronous, active low) sets all dimensions to 8 and idles the
// sequencer; A and B stores are not cleared and must be loaded before use.
// Configuration writes (rows_a, cols_b, inner_len) are taken any cycle and
// latched, clamped to 1..8, when a run starts.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit import mme_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [DIM_W-1:0]          i_cfg_data,
    // input words
    input  wire logic                      i_in_valid,
    output      logic                      o_in_stall,
    input  wire logic [MODE_W-1:0]         i_in_mode,
    input  wire logic [IDX_W-1:0]          i_in_row,
    input  wire logic [IDX_W-1:0]          i_in_col,
    input  wire logic signed [VALUE_W-1:0] i_in_value,
    // result words
    output      logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    output      logic [IDX_W-1:0]          o_out_out_row,
    output      logic [IDX_W-1:0]          o_out_out_col,
    output      logic signed [SUM_W-1:0]   o_out_sum,
    output      logic                      o_out_last
);

    // configuration registers
    logic [DIM_W-1:0] r_rows_a, r_cols_b, r_inner_len;

    // sequencer state
    t_state           r_state;
    logic [DIM_W-1:0] r_m, r_n, r_kd;        // clamped dims for this run
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic             r_rd_vld;
    logic             r_clr;

    // element stores
    logic signed [DATA_WIDTH-1:0] r_a_mem [MAX_DIM*MAX_DIM];
    logic signed [DATA_WIDTH-1:0] r_b_mem [MAX_DIM*MAX_DIM];
    logic signed [DATA_WIDTH-1:0] r_a_rd, r_b_rd;

    // output register
    logic                    r_out_vld;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_last_k, w_last_i, w_last_j;
    logic signed [SUM_W-1:0] w_acc;
    logic                    w_mac_busy;
    t_mac_ctl                w_mac_ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign w_last_k = ({1'b0, r_k} == r_kd - DIM_W'(1));
    assign w_last_i = ({1'b0, r_i} == r_m - DIM_W'(1));
    assign w_last_j = ({1'b0, r_j} == r_n - DIM_W'(1));

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
            r_inner_len <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stores: loads write only while idle, the run reads A[i][k] and B[k][j]
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_mode == MODE_LOAD_A)) begin
            r_a_mem[{i_in_row, i_in_col}] <= i_in_value[DATA_WIDTH-1:0];
        end
        r_a_rd <= r_a_mem[{r_i, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_mode == MODE_LOAD_B)) begin
            r_b_mem[{i_in_row, i_in_col}] <= i_in_value[DATA_WIDTH-1:0];
        end
        r_b_rd <= r_b_mem[{r_k, r_j}];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
            r_clr    <= 1'b0;
            r_m      <= DIM_RESET;
            r_n      <= DIM_RESET;
            r_kd     <= DIM_RESET;
        end else begin
            r_rd_vld <= 1'b0;
            r_clr    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_mode == MODE_RUN)) begin
                        r_m     <= clamp_dim(r_rows_a);
                        r_n     <= clamp_dim(r_cols_b);
                        r_kd    <= clamp_dim(r_inner_len);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_clr   <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_rd_vld <= 1'b1;
                    if (w_last_k) begin
                        r_k     <= '0;
                        r_state <= S_FLUSH;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_FLUSH: begin
                    if (!r_rd_vld && !w_mac_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (w_last_j) begin
                            r_j <= '0;
                            r_i <= r_i + IDX_W'(1);
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                        if (w_last_i && w_last_j) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_clr   <= 1'b1;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_mac_ctl.clr = r_clr;
    assign w_mac_ctl.vld = r_rd_vld;

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (r_a_rd),
        .i_b     (r_b_rd),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

    // output register: loads a finished element when the previous one is gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_row  <= r_i;
            r_out_col  <= r_j;
            r_out_sum  <= w_acc;
            r_out_last <= w_last_i && w_last_j;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_out_row = r_out_row;
    assign o_out_out_col = r_out_col;
    assign o_out_sum     = r_out_sum;
    assign o_out_last    = r_out_last;

`ifndef ASSERT_OFF
    // no pipeline activity may linger once the sequencer is idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_vld && !w_mac_busy))
        else $error("MAC pipeline active while idle");

    // a run word starts the walk on the next cycle
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_mode == MODE_RUN)) |=> (r_state == S_MAC))
        else $error("run word did not start the sequencer");

    // emit step waits while the output register is full and stalled
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_vld && i_out_stall) |=> (r_state == S_OUT))
        else $error("emit step left while output blocked");

    // element emission only from a drained pipeline
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!r_rd_vld && !w_mac_busy))
        else $error("element emitted before accumulation finished");
`endif

endmodule
`default_nettype wire

@@ rtl/mme_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// Registered signed product, then a 40-bit accumulator cleared per C element.
// ----------------------------------------------------------------------------
module mme_mac import mme_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_mac_ctl                     i_ctl,
    input  wire logic signed [DATA_WIDTH-1:0] i_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_b,
    output      logic signed [SUM_W-1:0]      o_acc,
    output      logic                         o_busy
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule
`default_nettype wire
